FILE: src/dleq_pkg.sv
// shared types and constants of the doubly linked entry queue
`default_nettype none

package dleq_pkg;

	// entry pool and link encoding
	localparam int NUM_ENTRIES = 16;
	localparam int ID_W        = 4;
	localparam int LINK_W      = ID_W + 1;
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_ENTRIES);

	// request kinds
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_DEQ   = 2'd1,
		KIND_REM   = 2'd2,
		KIND_QUERY = 2'd3
	} op_kind_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_LINK = 4'b0100,
		ST_POST = 4'b1000
	} state_t;

	// write request to a link memory
	typedef struct packed {
		logic              en;
		logic [ID_W-1:0]   addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

endpackage

`default_nettype wire

FILE: src/doubly_linked_entry_queue.sv
// an accepted item passes through EXEC, then LINK for a push onto a non-empty queue, then POST;
// one item at a time: a new item is taken only after the result enters the output register
// the pace is set by the single write port of the next link memory (written twice by a push
// onto a non-empty queue) and by the registered read of the link memories after acceptance
// reset clears head, tail, empty state, member bits and the output valid flag;
// link memories are not cleared, every link is written by a push before its value is used
`default_nettype none

module doubly_linked_entry_queue
	import dleq_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      kind,
	input  wire logic [ID_W-1:0] entry_id,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [ID_W-1:0]      result_id,
	output logic                 result_valid,
	output logic                 found,
	output logic                 is_empty,
	output logic                 error
);

	state_t                 state_q, state_d;
	op_kind_t               kind_q;
	logic [ID_W-1:0]        id_q;
	logic [ID_W-1:0]        head_q, head_d;
	logic [ID_W-1:0]        tail_q, tail_d;
	logic                   nonempty_q, nonempty_d;
	logic [NUM_ENTRIES-1:0] member_q, member_d;
	logic [ID_W-1:0]        link_addr_q;

	logic [ID_W-1:0]        res_id_q, res_id_d;
	logic                   res_valid_q, res_valid_d;
	logic                   res_found_q, res_found_d;
	logic                   res_err_q, res_err_d;

	logic                   out_valid_q;
	logic [ID_W-1:0]        out_id_q;
	logic                   out_rvalid_q, out_found_q, out_empty_q, out_err_q;

	logic                   accept;
	logic [ID_W-1:0]        rd_addr;
	logic [LINK_W-1:0]      rd_next, rd_prev;
	link_wr_t               next_wr, prev_wr;

	logic [ID_W-1:0]        tgt;
	logic                   tgt_head, tgt_tail;
	logic [ID_W-1:0]        nx_id, pv_id;
	logic                   nx_none, pv_none;
	logic                   out_free;

	// input handshake and link read address
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rd_addr  = (op_kind_t'(kind) == KIND_DEQ) ? head_q : entry_id;

	dleq_link_ram #(.DEPTH(NUM_ENTRIES), .WIDTH(LINK_W)) u_next_ram (
		.clk     (clk),
		.wr      (next_wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_next)
	);

	dleq_link_ram #(.DEPTH(NUM_ENTRIES), .WIDTH(LINK_W)) u_prev_ram (
		.clk     (clk),
		.wr      (prev_wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_prev)
	);

	// unlink target and its neighbours
	assign tgt      = (kind_q == KIND_DEQ) ? head_q : id_q;
	assign tgt_head = (tgt == head_q);
	assign tgt_tail = (tgt == tail_q);
	assign nx_id    = rd_next[ID_W-1:0];
	assign pv_id    = rd_prev[ID_W-1:0];
	assign nx_none  = rd_next[ID_W];
	assign pv_none  = rd_prev[ID_W];
	assign out_free = !out_valid_q || out_ready;

	// operation decode, list update and link writes
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		nonempty_d  = nonempty_q;
		member_d    = member_q;
		res_id_d    = '0;
		res_valid_d = 1'b0;
		res_found_d = 1'b0;
		res_err_d   = 1'b0;
		next_wr     = '0;
		prev_wr     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_POST;
				unique case (kind_q)
					KIND_PUSH: begin
						if (member_q[id_q]) begin
							res_err_d = 1'b1;
						end else begin
							next_wr = '{en: 1'b1, addr: id_q, data: LINK_NONE};
							prev_wr = '{en: 1'b1, addr: id_q,
								data: nonempty_q ? {1'b0, tail_q} : LINK_NONE};
							if (nonempty_q) begin
								state_d = ST_LINK;
							end else begin
								head_d = id_q;
							end
							tail_d          = id_q;
							nonempty_d      = 1'b1;
							member_d[id_q]  = 1'b1;
						end
					end
					KIND_QUERY: begin
						res_found_d = member_q[id_q];
					end
					default: begin
						// dequeue and remove share the unlink
						if ((kind_q == KIND_DEQ) ? !nonempty_q : !member_q[id_q]) begin
							res_err_d = 1'b1;
						end else begin
							priority if (tgt_head && tgt_tail) begin
								nonempty_d = 1'b0;
								head_d     = '0;
								tail_d     = '0;
							end else if (tgt_head) begin
								if (!nx_none) begin
									head_d  = nx_id;
									prev_wr = '{en: 1'b1, addr: nx_id, data: LINK_NONE};
								end
							end else if (tgt_tail) begin
								if (!pv_none) begin
									tail_d  = pv_id;
									next_wr = '{en: 1'b1, addr: pv_id, data: LINK_NONE};
								end
							end else begin
								if (!pv_none) begin
									next_wr = '{en: 1'b1, addr: pv_id, data: rd_next};
								end
								if (!nx_none) begin
									prev_wr = '{en: 1'b1, addr: nx_id, data: rd_prev};
								end
							end
							member_d[tgt] = 1'b0;
							if (kind_q == KIND_DEQ) begin
								res_id_d    = head_q;
								res_valid_d = 1'b1;
							end else if (!nx_none) begin
								res_id_d    = nx_id;
								res_valid_d = 1'b1;
							end
						end
					end
				endcase
			end
			ST_LINK: begin
				// old tail now points at the pushed entry
				next_wr = '{en: 1'b1, addr: link_addr_q, data: {1'b0, id_q}};
				state_d = ST_POST;
			end
			ST_POST: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			nonempty_q  <= 1'b0;
			member_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			nonempty_q <= nonempty_d;
			member_q   <= member_d;
			if (state_q == ST_POST && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture and result holding
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= op_kind_t'(kind);
			id_q   <= entry_id;
		end
		if (state_q == ST_EXEC) begin
			link_addr_q <= tail_q;
			res_id_q    <= res_id_d;
			res_valid_q <= res_valid_d;
			res_found_q <= res_found_d;
			res_err_q   <= res_err_d;
		end
		if (state_q == ST_POST && out_free) begin
			out_id_q     <= res_id_q;
			out_rvalid_q <= res_valid_q;
			out_found_q  <= res_found_q;
			out_empty_q  <= !nonempty_q;
			out_err_q    <= res_err_q;
		end
	end

	// output register
	assign out_valid    = out_valid_q;
	assign result_id    = out_id_q;
	assign result_valid = out_rvalid_q;
	assign found        = out_found_q;
	assign is_empty     = out_empty_q;
	assign error        = out_err_q;

endmodule

`default_nettype wire

FILE: src/dleq_link_ram.sv
// link word memory, one write port and one registered read port
`default_nettype none

module dleq_link_ram
	import dleq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 5
) (
	input  wire logic                     clk,
	input  wire link_wr_t                 wr,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[$clog2(DEPTH)-1:0]] <= wr.data[WIDTH-1:0];
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/dleq_checker.sv
// port-level checks of the doubly linked entry queue, bound to the top level
`default_nettype none

module dleq_checker
	import dleq_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [ID_W-1:0] result_id,
	input wire logic            result_valid,
	input wire logic            found,
	input wire logic            is_empty,
	input wire logic            error
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_id) && $stable(error))
		else $error("stalled result changed");

	// one item at a time: busy in the cycle after an acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// a refused request reports no entry and no membership
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !result_valid && !found)
		else $error("refused request carries a result");

	// a queued entry means the queue is not empty, and a membership answer carries no entry
	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !is_empty && !result_valid)
		else $error("membership answer inconsistent");

endmodule

bind doubly_linked_entry_queue dleq_checker u_dleq_checker (.*);

`default_nettype wire
